// ===== rtl/rtcp_ris_pkg.sv =====
package rtcp_ris_pkg;

  typedef struct packed {
    logic [15:0] sequence_number;
    logic [31:0] packet_ssrc;
    logic [31:0] now_seconds;
    logic [15:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic        send_report;
    logic [31:0] report_source_ssrc;
    logic [31:0] report_sender_ssrc;
    logic [31:0] extended_sequence;
    logic [31:0] scheduled_time;
  } out_item_t;

  typedef struct packed {
    logic [15:0] members_count;
    logic [15:0] senders_count;
    logic [19:0] rtcp_bandwidth;
    logic        we_sent_flag;
    logic [15:0] avg_packet_size;
    logic [31:0] own_ssrc;
  } cfg_regs_t;

  typedef struct packed {
    logic        start;
    logic [21:0] rem_init;
    logic [31:0] dividend;
    logic [21:0] divisor;
    logic [5:0]  steps;
  } div_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] quotient;
  } div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_PREP,
    S_DIV1,
    S_MUL2,
    S_LOAD2,
    S_DIV2,
    S_OUT
  } state_t;

  localparam logic [2:0] REG_MEMBERS  = 3'd0;
  localparam logic [2:0] REG_SENDERS  = 3'd1;
  localparam logic [2:0] REG_BW       = 3'd2;
  localparam logic [2:0] REG_WE_SENT  = 3'd3;
  localparam logic [2:0] REG_AVG_SIZE = 3'd4;
  localparam logic [2:0] REG_OWN_SSRC = 3'd5;

  localparam logic [31:0] MIN_Q      = 32'd327680;
  localparam logic [31:0] MIN_INIT_Q = 32'd163840;
  localparam logic [21:0] COMP_Q     = 22'd79841;
  localparam logic [16:0] HALF_Q     = 17'd32768;
  localparam logic [5:0]  DIV1_STEPS = 6'd32;
  localparam logic [5:0]  DIV2_STEPS = 6'd17;
  localparam logic [31:0] U32_MAX    = 32'hFFFF_FFFF;

endpackage

// ===== rtl/rtcp_report_interval_scheduler.sv =====
// RTCP receiver-report scheduler.
// in channel: one request per received RTP packet (in_valid/in_stall, payload
// in_data). in_stall is high while an earlier request is still being worked on.
// out channel: exactly one result per request (out_valid/out_stall, out_data),
// held in an output register; a result waiting under out_stall does not keep
// the next request out, but that request completes only once the register
// frees up.
// cfg channel: register writes (cfg_valid/cfg_ready, cfg_index, cfg_data),
// always ready; indexes 6 and 7 are ignored. Write only while idle.
// A request that does not trigger a report goes straight to the output state.
// A report request runs one 16x16 multiply, a 32-step restoring division, a
// 32x17 multiply and a 17-step division on the same divider (the first
// division is skipped when the base quotient saturates); the next request is
// taken only once the block is back in idle after the result is registered,
// so a new request is never taken before the last one is through.
// Reset (rst, synchronous): configuration returns to its defaults, sequence
// tracking and report times clear, cycle count becomes one, no result pending.
module rtcp_report_interval_scheduler
  import rtcp_ris_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_regs_t regs;
  div_cmd_t  div_cmd;
  div_stat_t div_stat;

  state_t state, state_next;

  logic [15:0] last_sequence;
  logic [15:0] cycle_count;
  logic [31:0] next_report_time;
  logic [31:0] last_report_time;

  logic [31:0] ssrc_q;
  logic [31:0] now_q;
  logic [15:0] rnd_q;
  logic        initial_q;
  logic        send_q;
  logic [21:0] den_q;
  logic [48:0] prod;
  logic [31:0] t_q;

  logic        accept;
  logic        due;
  logic        sat;
  logic        out_free;
  logic        small_senders;
  logic [15:0] n_sel;
  logic [21:0] den_sel;
  logic [31:0] min_q;
  logic [31:0] t_min;
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [48:0] mul_p;
  logic [32:0] sum;

  rtcp_ris_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  rtcp_ris_div u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (div_cmd),
    .stat (div_stat)
  );

  assign accept   = in_valid && !in_stall;
  assign due      = next_report_time < in_data.now_seconds;
  assign out_free = !out_valid || !out_stall;
  assign sat      = {4'd0, prod[31:14]} >= den_q;
  assign min_q    = initial_q ? MIN_INIT_Q : MIN_Q;
  assign t_min    = (t_q < min_q) ? min_q : t_q;
  assign mul_p    = {17'd0, mul_a} * {32'd0, mul_b};
  assign sum      = {1'b0, now_q} + {16'd0, div_stat.quotient[16:0]};

  assign small_senders = {regs.senders_count, 2'b00} <= {2'b00, regs.members_count};

  always_comb begin
    n_sel   = regs.members_count;
    den_sel = {regs.rtcp_bandwidth, 2'b00};
    if (small_senders) begin
      if (regs.we_sent_flag) begin
        n_sel   = regs.senders_count;
        den_sel = {2'b00, regs.rtcp_bandwidth};
      end else begin
        n_sel   = regs.members_count - regs.senders_count;
        den_sel = {2'b00, regs.rtcp_bandwidth} + {1'b0, regs.rtcp_bandwidth, 1'b0};
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = due ? S_MUL1 : S_OUT;
      S_MUL1:  state_next = S_PREP;
      S_PREP:  state_next = sat ? S_MUL2 : S_DIV1;
      S_DIV1:  if (!div_stat.busy) state_next = S_MUL2;
      S_MUL2:  state_next = S_LOAD2;
      S_LOAD2: state_next = S_DIV2;
      S_DIV2:  if (!div_stat.busy) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = state != S_IDLE;
    mul_a            = 32'd0;
    mul_b            = 17'd0;
    div_cmd.start    = 1'b0;
    div_cmd.rem_init = {4'd0, prod[31:14]};
    div_cmd.dividend = {prod[13:0], 18'd0};
    div_cmd.divisor  = den_q;
    div_cmd.steps    = DIV1_STEPS;
    unique case (state)
      S_MUL1: begin
        mul_a = {16'd0, regs.avg_packet_size};
        mul_b = {1'b0, n_sel};
      end
      S_PREP: begin
        div_cmd.start = !sat;
      end
      S_MUL2: begin
        mul_a = t_min;
        mul_b = {1'b0, rnd_q} + HALF_Q;
      end
      S_LOAD2: begin
        div_cmd.start    = 1'b1;
        div_cmd.rem_init = {6'd0, prod[48:33]};
        div_cmd.dividend = {prod[32:16], 15'd0};
        div_cmd.divisor  = COMP_Q;
        div_cmd.steps    = DIV2_STEPS;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      last_sequence    <= 16'd0;
      cycle_count      <= 16'd1;
      next_report_time <= 32'd0;
      last_report_time <= 32'd0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last_sequence <= in_data.sequence_number;
        if (in_data.sequence_number < last_sequence) begin
          cycle_count <= cycle_count + 16'd1;
        end
      end
      if (state == S_DIV2 && !div_stat.busy) begin
        next_report_time <= sum[32] ? U32_MAX : sum[31:0];
        last_report_time <= now_q;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ssrc_q    <= in_data.packet_ssrc;
      now_q     <= in_data.now_seconds;
      rnd_q     <= in_data.random_fraction;
      initial_q <= last_report_time == 32'd0;
      send_q    <= due;
    end
    if (state == S_MUL1) begin
      den_q <= den_sel;
    end
    if (state == S_MUL1 || state == S_MUL2) begin
      prod <= mul_p;
    end
    if (state == S_PREP && sat) begin
      t_q <= U32_MAX;
    end else if (state == S_DIV1 && !div_stat.busy) begin
      t_q <= div_stat.quotient;
    end
    if (state == S_OUT && out_free) begin
      out_data.send_report        <= send_q;
      out_data.report_source_ssrc <= ssrc_q;
      out_data.report_sender_ssrc <= regs.own_ssrc;
      out_data.extended_sequence  <= {cycle_count, last_sequence};
      out_data.scheduled_time     <= next_report_time;
    end
  end

endmodule

// ===== rtl/rtcp_ris_cfg.sv =====
module rtcp_ris_cfg
  import rtcp_ris_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_regs_t   regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.members_count   <= 16'd2;
      regs.senders_count   <= 16'd1;
      regs.rtcp_bandwidth  <= 20'd12;
      regs.we_sent_flag    <= 1'b0;
      regs.avg_packet_size <= 16'd52;
      regs.own_ssrc        <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MEMBERS:  regs.members_count   <= cfg_data[15:0];
        REG_SENDERS:  regs.senders_count   <= cfg_data[15:0];
        REG_BW:       regs.rtcp_bandwidth  <= cfg_data[19:0];
        REG_WE_SENT:  regs.we_sent_flag    <= cfg_data[0];
        REG_AVG_SIZE: regs.avg_packet_size <= cfg_data[15:0];
        REG_OWN_SSRC: regs.own_ssrc        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/rtcp_ris_div.sv =====
module rtcp_ris_div
  import rtcp_ris_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_cmd_t  cmd,
  output div_stat_t stat
);

  logic [21:0] rem;
  logic [31:0] quo;
  logic [21:0] divisor;
  logic [5:0]  count;
  logic        busy;
  logic [22:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem, quo[31]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= 6'd0;
    end else if (cmd.start) begin
      busy  <= 1'b1;
      count <= cmd.steps;
    end else if (busy) begin
      count <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem     <= cmd.rem_init;
      quo     <= cmd.dividend;
      divisor <= cmd.divisor;
    end else if (busy) begin
      rem <= fits ? 22'(rem_sh - {1'b0, divisor}) : rem_sh[21:0];
      quo <= {quo[30:0], fits};
    end
  end

  assign stat.busy     = busy;
  assign stat.quotient = quo;

endmodule
